@@ rtl/core/multichannel_biquad_with_tare_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel biquad with tare
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BIQUAD_WITH_TARE_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_WITH_TARE_ASSERT_SVH

`ifndef SYNTH
// Checked only while the reset is released.
`define MBQT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define MBQT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBQT_ASSERT(lbl, clk, rstn, prop, msg)
`define MBQT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/mbqt_pkg.sv @@
// ----------------------------------------------------------------------------
// mbqt_pkg
// Widths, codes and fixed-point helpers of the multichannel biquad with tare.
// ----------------------------------------------------------------------------
package mbqt_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned MAX_REPORT   = 8;

  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PROD_W    = COEF_W + SAMPLE_W;
  localparam int unsigned TERM_W    = PROD_W - FRAC_W;
  localparam int unsigned ACC_W     = TERM_W + 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = COEF_W;

  localparam int unsigned IN_TDATA_W  = ((CH_W + SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((CH_W + SAMPLE_W + 7) / 8) * 8;

  localparam logic signed [COEF_W-1:0] COEF_N0_RST = 18'sd65536;
  localparam logic [SCALE_W-1:0]       SCALE_RST   = 16'd7706;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TARE   = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_N0   = 3'd0,
    REG_COEF_N1   = 3'd1,
    REG_COEF_N2   = 3'd2,
    REG_COEF_D1   = 3'd3,
    REG_COEF_D2   = 3'd4,
    REG_OUT_SCALE = 3'd5
  } reg_idx_e;

  // Drop the fraction of a Q.16 product, rounding toward zero.
  function automatic logic signed [TERM_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{p[PROD_W-1]}}});
    return adj[PROD_W-1:FRAC_W];
  endfunction

  // Clamp to signed 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-SAMPLE_W:0] top;
    top = v[ACC_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      return v[SAMPLE_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/core/multichannel_biquad_with_tare.sv @@
// ----------------------------------------------------------------------------
// multichannel_biquad_with_tare
// Per-channel direct-form-I biquad with tare offsets and a scaled report.
// ----------------------------------------------------------------------------
// All arithmetic runs through one 18x16 signed multiplier with a registered
// product, stepped by a small sequencer; the input is not ready while an item
// is in work. A sample (tuser 0) runs five products, each a multiply step
// (S_MUL) then an accumulate step (S_ACC). A tare (tuser 1) and a report
// (tuser 2) run one such pair per channel for N = min(CHANNELS, 8) channels;
// a report also holds in S_ACC while the output stalls. Results sit in an
// output register, so the next item is taken while the last result waits.
// tuser 3 and samples for channels at or above CHANNELS are taken and dropped.
// History and offsets clear at reset. Configuration writes are always ready
// and must only be issued while the block is idle.

`include "multichannel_biquad_with_tare_assert.svh"

module multichannel_biquad_with_tare #(
  parameter int unsigned CHANNELS = mbqt_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mbqt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mbqt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mbqt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // channel[2:0], sample[18:3]
  input  logic [mbqt_pkg::ACT_W-1:0]          s_axis_tuser,  // action[1:0]
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mbqt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // out_channel[2:0], value[18:3]
  output logic                                m_axis_tlast
);

  import mbqt_pkg::*;

  // Only channels reachable by the 3-bit channel field hold state.
  localparam int unsigned NUM_CH = (CHANNELS < MAX_REPORT) ? CHANNELS : MAX_REPORT;
  localparam int unsigned IDX_W  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int unsigned CHK_W  = CH_W + 1;

  localparam logic [2:0] TERM_X0 = 3'd0;
  localparam logic [2:0] TERM_X1 = 3'd1;
  localparam logic [2:0] TERM_X2 = 3'd2;
  localparam logic [2:0] TERM_Y1 = 3'd3;
  localparam logic [2:0] TERM_Y2 = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_ACC  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  action_e                   op_q, op_d;
  logic [2:0]                step_q, step_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;

  logic signed [COEF_W-1:0]  n0_q, n1_q, n2_q, d1_q, d2_q;
  logic [SCALE_W-1:0]        scale_q;

  logic signed [SAMPLE_W-1:0] x1_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] x2_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] y1_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] y2_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] off_q [NUM_CH];

  logic signed [COEF_W-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   prod, prod_q;
  logic signed [TERM_W-1:0]   term;
  logic signed [ACC_W-1:0]    term_x, acc_sum;

  logic                       hist_we, off_we, out_load, last_idx;
  logic signed [SAMPLE_W-1:0] y_new, off_new, out_val_new;

  logic                       m_valid_q;
  logic [CH_W-1:0]            out_ch_q;
  logic signed [SAMPLE_W-1:0] out_val_q;
  logic                       out_last_q;

  logic [CH_W-1:0]            s_channel;
  logic signed [SAMPLE_W-1:0] s_sample;

  assign s_channel     = s_axis_tdata[CH_W-1:0];
  assign s_sample      = s_axis_tdata[CH_W +: SAMPLE_W];
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n0_q    <= COEF_N0_RST;
      n1_q    <= '0;
      n2_q    <= '0;
      d1_q    <= '0;
      d2_q    <= '0;
      scale_q <= SCALE_RST;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_COEF_N0:   n0_q    <= cfg_data_i;
        REG_COEF_N1:   n1_q    <= cfg_data_i;
        REG_COEF_N2:   n2_q    <= cfg_data_i;
        REG_COEF_D1:   d1_q    <= cfg_data_i;
        REG_COEF_D2:   d2_q    <= cfg_data_i;
        REG_OUT_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (op_q == ACT_SAMPLE) begin
      case (step_q)
        TERM_X0: begin mul_a = n0_q; mul_b = sample_q;   end
        TERM_X1: begin mul_a = n1_q; mul_b = x1_q[idx_q]; end
        TERM_X2: begin mul_a = n2_q; mul_b = x2_q[idx_q]; end
        TERM_Y1: begin mul_a = d1_q; mul_b = y1_q[idx_q]; end
        TERM_Y2: begin mul_a = d2_q; mul_b = y2_q[idx_q]; end
        default: ;
      endcase
    end else begin
      mul_a = $signed({{(COEF_W-SCALE_W){1'b0}}, scale_q});
      mul_b = y1_q[idx_q];
    end
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_q <= prod;
    end
  end

  assign term     = trunc_q16(prod_q);
  assign term_x   = ACC_W'(term);
  assign last_idx = (idx_q == IDX_W'(NUM_CH - 1));

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    step_d      = step_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    sample_d    = sample_q;
    hist_we     = 1'b0;
    off_we      = 1'b0;
    out_load    = 1'b0;
    y_new       = '0;
    off_new     = '0;
    out_val_new = '0;
    acc_sum     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            ACT_SAMPLE: begin
              if ({1'b0, s_channel} < CHK_W'(NUM_CH)) begin
                op_d     = ACT_SAMPLE;
                idx_d    = IDX_W'(s_channel);
                sample_d = s_sample;
                step_d   = TERM_X0;
                acc_d    = '0;
                state_d  = S_MUL;
              end
            end
            ACT_TARE, ACT_REPORT: begin
              op_d    = action_e'(s_axis_tuser);
              idx_d   = '0;
              step_d  = TERM_X0;
              state_d = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        case (op_q)
          ACT_SAMPLE: begin
            acc_sum = (step_q >= TERM_Y1) ? acc_q - term_x : acc_q + term_x;
            if (step_q == TERM_Y2) begin
              hist_we = 1'b1;
              y_new   = sat16(acc_sum);
              state_d = S_IDLE;
            end else begin
              acc_d   = acc_sum;
              step_d  = step_q + 3'd1;
              state_d = S_MUL;
            end
          end
          ACT_TARE: begin
            off_we  = 1'b1;
            off_new = sat16(term_x);
            if (last_idx) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_MUL;
            end
          end
          ACT_REPORT: begin
            // hold the product until the result register frees up
            if (!m_valid_q || m_axis_tready) begin
              out_load    = 1'b1;
              out_val_new = sat16(term_x - ACC_W'(off_q[idx_q]));
              if (last_idx) begin
                state_d = S_IDLE;
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = S_MUL;
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= ACT_SAMPLE;
      step_q  <= '0;
      idx_q   <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  // per-channel history and offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        x1_q[i]  <= '0;
        x2_q[i]  <= '0;
        y1_q[i]  <= '0;
        y2_q[i]  <= '0;
        off_q[i] <= '0;
      end
    end else begin
      if (hist_we) begin
        x2_q[idx_q] <= x1_q[idx_q];
        x1_q[idx_q] <= sample_q;
        y2_q[idx_q] <= y1_q[idx_q];
        y1_q[idx_q] <= y_new;
      end
      if (off_we) begin
        off_q[idx_q] <= off_new;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= CH_W'(idx_q);
      out_val_q  <= out_val_new;
      out_last_q <= last_idx;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-CH_W-SAMPLE_W){1'b0}}, out_val_q, out_ch_q};
  assign m_axis_tlast  = out_last_q;

  `MBQT_ASSERT(a_last_on_final_channel, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[CH_W-1:0] == CH_W'(NUM_CH - 1), "tlast on a channel other than the final one")
  `MBQT_ASSERT(a_step_in_range, clk_i, rst_ni, state_q != S_IDLE |-> step_q <= TERM_Y2, "term counter past the last product")
  `MBQT_ASSERT(a_busy_after_sample, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_SAMPLE && {1'b0, s_axis_tdata[CH_W-1:0]} < CHK_W'(NUM_CH) |=> !s_axis_tready, "ready right after taking a sample")
  `MBQT_ASSERT(a_result_from_acc, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(state_q == S_ACC && op_q == ACT_REPORT), "result appeared outside a report step")
  `MBQT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid && s_axis_tready, "not quiet in reset")

endmodule
